// ----- hw/rtl/bole_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, operation codes and types of the bounded ordered list engine.
// Used by bole_cell, bole_ctrl and bounded_ordered_list_engine; depends on nothing.
package bole_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int KIND_W = 3;
	localparam int POS_W  = 7;
	localparam int STAT_W = 2;
	localparam int OUT_W  = 7;
	localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 24;

	// Operation kinds carried by an input item.
	localparam logic [KIND_W-1:0] K_INS_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] K_INS_END   = 3'd1;
	localparam logic [KIND_W-1:0] K_INS_POS   = 3'd2;
	localparam logic [KIND_W-1:0] K_DEL_POS   = 3'd3;
	localparam logic [KIND_W-1:0] K_DEL_VAL   = 3'd4;
	localparam logic [KIND_W-1:0] K_SEARCH    = 3'd5;
	localparam logic [KIND_W-1:0] K_CLEAR     = 3'd6;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

	// Commands broadcast to every cell of the chain.
	localparam logic [1:0] CMD_HOLD = 2'd0;
	localparam logic [1:0] CMD_INS  = 2'd1;
	localparam logic [1:0] CMD_DEL  = 2'd2;
	localparam logic [1:0] CMD_ROT  = 2'd3;

	typedef struct packed {
		logic [1:0]        op;
		logic [IDX_W-1:0]  idx;
		logic              keep;
		logic [DATA_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [OUT_W-1:0]  count;
		logic [OUT_W-1:0]  removed;
		logic              found;
		logic [STAT_W-1:0] status;
	} res_t;

endpackage

// ----- hw/rtl/bole_cell.sv -----
`timescale 1ns / 1ps
// One list cell: holds a single entry and trades it with its neighbors.
// Depends on bole_pkg for the command struct and widths.
module bole_cell (
	input  logic                           clk,
	input  bole_pkg::cmd_t                 cmd,
	input  logic [bole_pkg::IDX_W-1:0]     my_idx,
	input  logic [bole_pkg::DATA_W-1:0]    left,
	input  logic [bole_pkg::DATA_W-1:0]    right,
	output logic [bole_pkg::DATA_W-1:0]    q
);
	import bole_pkg::*;

	logic [DATA_W-1:0] val_q;

	assign q = val_q;

	// Insert opens a gap by shifting up, delete closes one by shifting down, and a
	// rotate step moves the list toward the head while the old head, if kept, rejoins at the tail.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_INS: begin
				if (my_idx == cmd.idx) begin
					val_q <= cmd.data;
				end else if (my_idx > cmd.idx) begin
					val_q <= left;
				end
			end
			CMD_DEL: begin
				if (my_idx >= cmd.idx) begin
					val_q <= right;
				end
			end
			CMD_ROT: begin
				if (my_idx < cmd.idx) begin
					val_q <= right;
				end else if (my_idx == cmd.idx && cmd.keep) begin
					val_q <= cmd.data;
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

endmodule

// ----- hw/rtl/bole_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the list engine: decodes operations, keeps the count, drives the
// cell chain and holds the result register. Depends on bole_pkg.
module bole_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bole_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bole_pkg::M_TDATA_W-1:0]    m_tdata,
	input  logic [bole_pkg::DATA_W-1:0]       head,
	output bole_pkg::cmd_t                    cmd
);
	import bole_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  steps_q;
	logic [CNT_W-1:0]  removed_q;
	logic              found_q;
	logic              search_q;
	logic [DATA_W-1:0] v_q;
	res_t              res_q;
	logic              out_valid_q;

	logic              out_free;
	logic              fire;
	logic [KIND_W-1:0] kind;
	logic [DATA_W-1:0] val;
	logic [POS_W-1:0]  pos;
	logic [CMP_W-1:0]  cnt_w;
	logic [CMP_W-1:0]  pos_w;
	logic              full;
	logic              imm_load;
	logic              start_scan;
	logic [STAT_W-1:0] st;
	logic              fnd;
	logic [CNT_W-1:0]  rem;
	logic [CNT_W-1:0]  cnt_nx;
	logic              fin_load;
	logic              drop;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign fire     = s_tvalid && s_tready;

	assign kind  = s_tdata[KIND_W-1:0];
	assign val   = s_tdata[KIND_W +: DATA_W];
	assign pos   = s_tdata[KIND_W + DATA_W +: POS_W];
	assign cnt_w = CMP_W'(count_q);
	assign pos_w = CMP_W'(pos);
	assign full  = (count_q >= CNT_W'(DEPTH));

	assign fin_load = (state_q == ST_FIN) && out_free;
	assign drop     = (state_q == ST_SCAN) && !cmd.keep;

	always_comb begin
		cmd        = '{op: CMD_HOLD, idx: '0, keep: 1'b0, data: val};
		imm_load   = 1'b0;
		start_scan = 1'b0;
		st         = ST_DONE;
		fnd        = 1'b0;
		rem        = '0;
		cnt_nx     = count_q;
		if (state_q == ST_SCAN) begin
			// The head leaves the chain and rejoins at the tail unless it matches
			// the value being deleted.
			cmd.op   = CMD_ROT;
			cmd.idx  = IDX_W'(count_q - CNT_W'(1));
			cmd.data = head;
			cmd.keep = search_q || (head != v_q);
		end else if (fire) begin
			imm_load = 1'b1;
			case (kind)
				K_INS_FRONT, K_INS_END: begin
					if (full) begin
						st = ST_FULL;
					end else begin
						cmd.op  = CMD_INS;
						cmd.idx = (kind == K_INS_FRONT) ? '0 : IDX_W'(count_q);
						cnt_nx  = count_q + CNT_W'(1);
					end
				end
				K_INS_POS: begin
					if (pos == '0 || pos_w > cnt_w + CMP_W'(1)) begin
						st = ST_BADPOS;
					end else if (full) begin
						st = ST_FULL;
					end else begin
						cmd.op  = CMD_INS;
						cmd.idx = IDX_W'(pos - POS_W'(1));
						cnt_nx  = count_q + CNT_W'(1);
					end
				end
				K_DEL_POS: begin
					if (count_q == '0 || pos == '0 || pos_w > cnt_w) begin
						st = ST_BADPOS;
					end else begin
						cmd.op  = CMD_DEL;
						cmd.idx = IDX_W'(pos - POS_W'(1));
						rem     = CNT_W'(1);
						cnt_nx  = count_q - CNT_W'(1);
					end
				end
				K_DEL_VAL, K_SEARCH: begin
					if (count_q != '0) begin
						imm_load   = 1'b0;
						start_scan = 1'b1;
					end
				end
				K_CLEAR: begin
					rem    = count_q;
					cnt_nx = '0;
				end
				default: begin
					st = ST_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			steps_q     <= '0;
			removed_q   <= '0;
			found_q     <= 1'b0;
			search_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					count_q <= cnt_nx;
					if (start_scan) begin
						state_q   <= ST_SCAN;
						steps_q   <= count_q;
						removed_q <= '0;
						found_q   <= 1'b0;
						search_q  <= (kind == K_SEARCH);
					end
				end
				ST_SCAN: begin
					if (drop) begin
						count_q   <= count_q - CNT_W'(1);
						removed_q <= removed_q + CNT_W'(1);
					end
					if (search_q && head == v_q) begin
						found_q <= 1'b1;
					end
					steps_q <= steps_q - CNT_W'(1);
					if (steps_q == CNT_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (imm_load || fin_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_scan) begin
			v_q <= val;
		end
		if (imm_load) begin
			res_q <= '{count: OUT_W'(cnt_nx), removed: OUT_W'(rem), found: fnd, status: st};
		end else if (fin_load) begin
			res_q <= '{count: OUT_W'(count_q), removed: OUT_W'(removed_q),
				found: found_q, status: ST_DONE};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(res_q);

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("list count exceeds the list depth");

	a_scan_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> steps_q != '0 && steps_q <= count_q + removed_q)
		else $error("scan step counter out of range");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind == K_CLEAR) |=> count_q == '0 && res_q.removed == OUT_W'($past(count_q)))
		else $error("clear did not empty the list");

	a_search_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && search_q) |=> count_q == $past(count_q))
		else $error("search changed the list count");

endmodule

// ----- hw/rtl/bounded_ordered_list_engine.sv -----
`timescale 1ns / 1ps
// Top level of the bounded ordered list engine: a chain of list cells and its
// sequencer. Depends on bole_pkg, bole_cell and bole_ctrl.
//
// Usage: each transaction on the s_ channel carries one list operation (insert
// at front, at end or at a 1-based position, delete at a position, delete every
// entry equal to a value, search, clear). Each operation returns exactly one
// result transaction on the m_ channel with status, search hit, entries removed
// and the count after the operation.
// Insert, delete at a position and clear finish in the cycle they are accepted;
// the result is valid on the next cycle. Delete by value and search rotate the
// whole list once through the cell chain, one entry per cycle, and their result
// is valid after the last entry has passed. One operation is worked on at a time.
// A new operation is accepted while the previous result waits, as long as the
// receiver takes that result in the same cycle; while the receiver stalls the
// result register holds and s_tready stays low.
// Reset empties the list at once; the cell contents are not cleared and are
// never read before they are written.
module bounded_ordered_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // kind[2:0], value[34:3], position[41:35], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // status[1:0], found[2], removed[9:3], count[16:10], zero fill
);
	import bole_pkg::*;

	cmd_t              cmd;
	logic [DATA_W-1:0] cell_q [DEPTH];

	bole_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.head     (cell_q[0]),
		.cmd      (cmd)
	);

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam int LN = (g == 0) ? 0 : g - 1;
		localparam int RN = (g == DEPTH - 1) ? g : g + 1;

		bole_cell u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.my_idx (IDX_W'(g)),
			.left   (cell_q[LN]),
			.right  (cell_q[RN]),
			.q      (cell_q[g])
		);
	end

endmodule

// ----- sim/bounded_ordered_list_engine_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bounded_ordered_list_engine: list operations are streamed in
// and every result is checked against a list model kept here. Depends on bole_pkg.
module bounded_ordered_list_engine_tb;
	import bole_pkg::*;

	localparam int N_ITEMS        = 1350;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int HOLD_CYCLES    = 300;
	localparam int HOLD_AT        = 700;
	localparam int CALM_FROM      = 300;
	localparam int CALM_TO        = 450;

	// The one kind code the block leaves unused.
	localparam logic [KIND_W-1:0] K_UNUSED = 3'd7;

	typedef logic [DATA_W-1:0] word_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		word_t             value;
		logic [POS_W-1:0]  pos;
	} list_op_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	list_op_t pending_ops[$];
	res_t     awaited_results[$];
	word_t    list_plan[$];
	word_t    list_now[$];
	word_t    value_pool[8];

	list_op_t cur_op;
	res_t     predicted;
	res_t     want_res;
	res_t     got_res;
	int       send_gap    = 0;
	int       recv_gap    = 0;
	int       hold_left   = 0;
	bit       held        = 1'b0;
	int       idle_cycles = 0;
	int       n_accepted  = 0;
	int       n_checked   = 0;
	int       n_errors    = 0;
	int       n_full      = 0;
	int       n_badpos    = 0;
	int       peak_fill   = 0;
	int       kind_seen[8];

	bounded_ordered_list_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial forever #2 clk = ~clk;

	// Applies one operation to a list and returns the result the block must give.
	function automatic res_t list_apply(ref word_t lst[$], input list_op_t op);
		res_t  r;
		int    n;
		int    p;
		word_t kept[$];
		r = '0;
		n = lst.size();
		p = int'(op.pos);
		case (op.kind)
			K_INS_FRONT, K_INS_END: begin
				if (n >= DEPTH)
					r.status = ST_FULL;
				else if (op.kind == K_INS_FRONT)
					lst.push_front(op.value);
				else
					lst.push_back(op.value);
			end
			K_INS_POS: begin
				// The position check takes priority over the full check.
				if (p < 1 || p > n + 1)
					r.status = ST_BADPOS;
				else if (n >= DEPTH)
					r.status = ST_FULL;
				else
					lst.insert(p - 1, op.value);
			end
			K_DEL_POS: begin
				if (n == 0 || p < 1 || p > n) begin
					r.status = ST_BADPOS;
				end else begin
					lst.delete(p - 1);
					r.removed = OUT_W'(1);
				end
			end
			K_DEL_VAL: begin
				foreach (lst[i])
					if (lst[i] != op.value)
						kept.push_back(lst[i]);
				r.removed = OUT_W'(n - kept.size());
				lst = kept;
			end
			K_SEARCH: begin
				foreach (lst[i])
					if (lst[i] == op.value)
						r.found = 1'b1;
			end
			K_CLEAR: begin
				r.removed = OUT_W'(n);
				lst.delete();
			end
			default: ;
		endcase
		r.count = OUT_W'(lst.size());
		return r;
	endfunction

	function automatic int draw_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	function automatic word_t pick_value();
		if ($urandom_range(0, 9) < 7)
			return value_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	// A value taken from the planned list half the time when it is not empty, so searches and deletes hit.
	function automatic word_t pick_present();
		if (list_plan.size() != 0 && $urandom_range(0, 1) == 0)
			return list_plan[$urandom_range(0, list_plan.size() - 1)];
		return pick_value();
	endfunction

	task automatic queue_op(input logic [KIND_W-1:0] k, input word_t v, input int p);
		list_op_t op;
		op.kind  = k;
		op.value = v;
		op.pos   = POS_W'(p);
		void'(list_apply(list_plan, op));
		pending_ops.push_back(op);
	endtask

	task automatic compare_field(input string what, input int want, input int seen);
		if (want != seen) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
			n_errors++;
		end
	endtask

	// Driver: offers pending operations and predicts each one as its transaction completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predicted = list_apply(list_now, cur_op);
				awaited_results.push_back(predicted);
				n_accepted++;
				kind_seen[cur_op.kind]++;
				if (predicted.status == ST_FULL)
					n_full++;
				if (predicted.status == ST_BADPOS)
					n_badpos++;
				if (list_now.size() > peak_fill)
					peak_fill = list_now.size();
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					cur_op = pending_ops.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {6'b0, cur_op.pos, cur_op.value, cur_op.kind};
					send_gap = draw_gap(n_accepted >= CALM_FROM && n_accepted < CALM_TO);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every result transaction and drives the receiver's stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res = m_tdata[16:0];
				if (awaited_results.size() == 0) begin
					$display("%0t ns: result with no operation outstanding, expected none, got %h",
						$time, m_tdata);
					n_errors++;
				end else begin
					want_res = awaited_results.pop_front();
					compare_field("status", int'(want_res.status), int'(got_res.status));
					compare_field("found", int'(want_res.found), int'(got_res.found));
					compare_field("removed", int'(want_res.removed), int'(got_res.removed));
					compare_field("count", int'(want_res.count), int'(got_res.count));
					compare_field("zero fill", 0, int'(m_tdata[23:17]));
				end
				n_checked++;
			end
			// One long hold-off lets the block fill up and push back on its input.
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!held && n_checked >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap = draw_gap(n_checked >= CALM_FROM && n_checked < CALM_TO);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: watchdog expired after %0d cycles without a transaction",
					$time, idle_cycles);
				$display("Test completed with failures");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int r;
		int n;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h7FFF_FFFF;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom();

		// Operations on an empty list, then the unused kind.
		queue_op(K_DEL_POS, 32'h0, 1);
		queue_op(K_SEARCH, 32'h0, 0);
		queue_op(K_DEL_VAL, 32'h0, 0);
		queue_op(K_CLEAR, 32'h0, 0);
		queue_op(K_UNUSED, 32'hFFFF_FFFF, 127);
		// Insert positions below, at and past the valid range.
		queue_op(K_INS_POS, 32'h1234_5678, 0);
		queue_op(K_INS_POS, 32'h1234_5678, 2);
		queue_op(K_INS_POS, 32'h8000_0000, 1);
		queue_op(K_INS_FRONT, 32'h7FFF_FFFF, 0);
		queue_op(K_INS_END, 32'h0000_0000, 0);
		queue_op(K_INS_END, 32'hFFFF_FFFF, 0);
		queue_op(K_INS_POS, 32'h0000_0001, 5);
		queue_op(K_INS_POS, 32'h0000_0001, 127);
		queue_op(K_SEARCH, 32'h8000_0000, 0);
		queue_op(K_SEARCH, 32'h0000_0005, 0);
		// Delete positions outside the list, then the last and the first entry.
		queue_op(K_DEL_POS, 32'h0, 0);
		queue_op(K_DEL_POS, 32'h0, 127);
		queue_op(K_DEL_POS, 32'h0, 5);
		queue_op(K_DEL_POS, 32'h0, 1);
		// Several copies of one value go in a single delete by value.
		queue_op(K_INS_END, 32'h0000_0000, 0);
		queue_op(K_INS_FRONT, 32'h0000_0000, 0);
		queue_op(K_DEL_VAL, 32'h0000_0000, 0);
		queue_op(K_CLEAR, 32'h0, 0);

		while (pending_ops.size() < N_ITEMS) begin
			n = list_plan.size();
			r = $urandom_range(0, 99);
			if (r < 3) begin
				// Fill the list to capacity, then probe the full-list behavior.
				while (list_plan.size() < DEPTH) begin
					case ($urandom_range(0, 2))
						0: queue_op(K_INS_FRONT, pick_value(), 0);
						1: queue_op(K_INS_END, pick_value(), 0);
						default: queue_op(K_INS_POS, pick_value(),
							$urandom_range(1, list_plan.size() + 1));
					endcase
				end
				queue_op(K_INS_FRONT, pick_value(), 0);
				queue_op(K_INS_END, pick_value(), 0);
				queue_op(K_INS_POS, pick_value(), DEPTH + 1);
				queue_op(K_INS_POS, pick_value(), $urandom_range(1, DEPTH));
				queue_op(K_INS_POS, pick_value(), DEPTH + 2);
				queue_op(K_SEARCH, pick_present(), 0);
				queue_op(K_DEL_POS, 32'h0, DEPTH);
			end else if (r < 20) begin
				queue_op(K_INS_END, pick_value(), 0);
			end else if (r < 30) begin
				queue_op(K_INS_FRONT, pick_value(), 0);
			end else if (r < 45) begin
				queue_op(K_INS_POS, pick_value(), $urandom_range(1, n + 1));
			end else if (r < 62) begin
				queue_op(K_DEL_POS, $urandom(), (n == 0) ? 1 : $urandom_range(1, n));
			end else if (r < 70) begin
				queue_op(K_DEL_VAL, pick_present(), $urandom_range(0, 127));
			end else if (r < 82) begin
				queue_op(K_SEARCH, pick_present(), $urandom_range(0, 127));
			end else if (r < 85) begin
				queue_op(K_CLEAR, $urandom(), $urandom_range(0, 127));
			end else if (r < 87) begin
				queue_op(K_UNUSED, $urandom(), $urandom_range(0, 127));
			end else begin
				// Noise: any kind, any value, any position.
				queue_op(KIND_W'($urandom_range(0, 7)), $urandom(), $urandom_range(0, 127));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || s_tvalid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d operations: %0d inserts, %0d position deletes, %0d value deletes, %0d searches, %0d clears, %0d of the unused kind.",
			n_accepted, kind_seen[K_INS_FRONT] + kind_seen[K_INS_END] + kind_seen[K_INS_POS],
			kind_seen[K_DEL_POS], kind_seen[K_DEL_VAL], kind_seen[K_SEARCH],
			kind_seen[K_CLEAR], kind_seen[K_UNUSED]);
		$display("Checked %0d results, with %0d full-list and %0d bad-position rejects; the list peaked at %0d entries.",
			n_checked, n_full, n_badpos, peak_fill);
		if (n_errors == 0 && awaited_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/bole_pkg.sv
hw/rtl/bole_cell.sv
hw/rtl/bole_ctrl.sv
hw/rtl/bounded_ordered_list_engine.sv
sim/bounded_ordered_list_engine_tb.sv
